// File: hdl/secc_pkg.sv
`timescale 1ns / 1ps

package secc_pkg;

  // Fixed-point format of positions and windows.
  localparam int FRAC_BITS = 31;
  localparam int POS_W = 64;

  // Field widths of the item and configuration port.
  localparam int KIND_W = 2;
  localparam int COUNT_W = 32;
  localparam int WINDOW_W = 62;
  localparam int RATIO_W = 36;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WINDOW_W;

  // One whole step in fixed point.
  localparam logic [POS_W-1:0] STEP_ONE = 64'd1 << FRAC_BITS;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENC_PRESENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_PER_STEP = 2'd3;

  // One input request as held in the input stage.
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic                      direction;
    logic signed [COUNT_W-1:0] encoder_count;
    logic signed [COUNT_W-1:0] load_position;
  } item_t;

  // Configuration write bundle.
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: hdl/secc_in_if.sv
`timescale 1ns / 1ps

interface secc_in_if;
  import secc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic                      direction;
  logic signed [COUNT_W-1:0] encoder_count;
  logic signed [COUNT_W-1:0] load_position;

  modport source (
    output valid, kind, direction, encoder_count, load_position,
    input  ready
  );

  modport sink (
    input  valid, kind, direction, encoder_count, load_position,
    output ready
  );

endinterface

// File: hdl/secc_out_if.sv
`timescale 1ns / 1ps

interface secc_out_if;

  logic valid;
  logic ready;
  logic flag;

  modport source (
    output valid, flag,
    input  ready
  );

  modport sink (
    input  valid, flag,
    output ready
  );

endinterface

// File: hdl/secc_engine.sv
`timescale 1ns / 1ps

module secc_engine
  import secc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output logic    flag
);

  // Configuration registers.
  logic                enc_present_r;
  logic [WINDOW_W-1:0] step_window_r;
  logic [WINDOW_W-1:0] enc_window_r;
  logic [RATIO_W-1:0]  enc_per_step_r;

  // Tracking state.
  logic [POS_W-1:0] step_pos_r, step_pos_nxt;
  logic [POS_W-1:0] upper_r, upper_nxt;
  logic [POS_W-1:0] lower_r, lower_nxt;
  logic [POS_W-1:0] ideal_r, ideal_nxt;

  logic [POS_W-1:0]         sw_ext;
  logic [POS_W-1:0]         ew_ext;
  logic [POS_W-1:0]         moved_pos;
  logic [POS_W-1:0]         meas;
  logic [POS_W-1:0]         diff;
  logic [POS_W-1:0]         diff_neg;
  logic [POS_W-1:0]         load_ext;
  logic [POS_W-1:0]         load_fix;
  logic signed [POS_W+4:0]  load_prod;
  logic                     over_upper;
  logic                     under_lower;

  assign sw_ext = {{(POS_W-WINDOW_W){1'b0}}, step_window_r};
  assign ew_ext = {{(POS_W-WINDOW_W){1'b0}}, enc_window_r};

  // Step: move one whole step, then test the window against the new position.
  assign moved_pos   = item.direction ? step_pos_r + STEP_ONE : step_pos_r - STEP_ONE;
  assign over_upper  = $signed(moved_pos) > $signed(upper_r);
  assign under_lower = $signed(lower_r) > $signed(moved_pos);

  // Check: both signs of the error are formed so only one compare follows.
  assign meas     = {{(POS_W-COUNT_W){item.encoder_count[COUNT_W-1]}}, item.encoder_count}
                    << FRAC_BITS;
  assign diff     = ideal_r - meas;
  assign diff_neg = meas - ideal_r;

  // Load: fixed-point position and ideal encoder count.
  assign load_ext  = {{(POS_W-COUNT_W){item.load_position[COUNT_W-1]}}, item.load_position};
  assign load_fix  = load_ext << FRAC_BITS;
  assign load_prod = item.load_position * $signed({1'b0, enc_per_step_r});

  // Next state and flag for the request in the input stage.
  always_comb begin
    step_pos_nxt = step_pos_r;
    upper_nxt    = upper_r;
    lower_nxt    = lower_r;
    ideal_nxt    = ideal_r;
    flag         = 1'b0;
    case (item.kind)
      KIND_STEP: begin
        if (enc_present_r) begin
          step_pos_nxt = moved_pos;
          if (over_upper) begin
            upper_nxt = upper_r + sw_ext;
            lower_nxt = lower_r + sw_ext;
            ideal_nxt = ideal_r + ew_ext;
            flag      = 1'b1;
          end else if (under_lower) begin
            upper_nxt = upper_r - sw_ext;
            lower_nxt = lower_r - sw_ext;
            ideal_nxt = ideal_r - ew_ext;
            flag      = 1'b1;
          end
        end
      end
      KIND_CHECK: begin
        if (!enc_present_r) begin
          flag = 1'b1;
        end else if (diff[POS_W-1]) begin
          flag = (diff_neg <= ew_ext);
        end else begin
          flag = (diff <= ew_ext);
        end
      end
      KIND_LOAD: begin
        step_pos_nxt = load_fix;
        upper_nxt    = load_fix + sw_ext;
        lower_nxt    = load_fix - sw_ext;
        ideal_nxt    = load_prod[POS_W-1:0];
      end
      default: begin
        flag = 1'b0;
      end
    endcase
  end

  // Configuration writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_present_r  <= 1'b0;
      step_window_r  <= '0;
      enc_window_r   <= '0;
      enc_per_step_r <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_ENC_PRESENT:  enc_present_r  <= cfg.data[0];
        REG_STEP_WINDOW:  step_window_r  <= cfg.data[WINDOW_W-1:0];
        REG_ENC_WINDOW:   enc_window_r   <= cfg.data[WINDOW_W-1:0];
        REG_ENC_PER_STEP: enc_per_step_r <= cfg.data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tracking state advances once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_pos_r <= '0;
      upper_r    <= '0;
      lower_r    <= '0;
      ideal_r    <= '0;
    end else if (fire) begin
      step_pos_r <= step_pos_nxt;
      upper_r    <= upper_nxt;
      lower_r    <= lower_nxt;
      ideal_r    <= ideal_nxt;
    end
  end

endmodule

// File: hdl/stepper_encoder_stall_check.sv
`timescale 1ns / 1ps

// Stepper encoder stall check. Each request is a step, an encoder check or a
// position load, and each gives exactly one result flag. A request is taken
// into an input register. From there it is processed against the tracking
// state (position, window bounds, ideal encoder count) once the result
// register is free or drains, and its flag is loaded into the result register.
// The result is therefore presented from the result register. The tracking
// state is updated at the same clock edge as the flag is loaded, so a new
// request can be accepted every cycle. The sustained rate is one request per
// clock as long as results are taken. When the result side stalls, the two
// registers fill and the input stalls with it. The user must write the
// configuration registers through the cfg port only while no request is in
// flight (the block does not enforce this); a position load should follow any configuration change.

module stepper_encoder_stall_check
  import secc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  secc_in_if.sink               in_ch,
  secc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  logic    out_flag_r;
  logic    fire;
  logic    flag;
  cfg_wr_t cfg;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

  // The input stage is processed when the result register is free or drains.
  assign fire        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= '{kind:          in_ch.kind,
                     direction:     in_ch.direction,
                     encoder_count: in_ch.encoder_count,
                     load_position: in_ch.load_position};
    end
  end

  secc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (in_item_r),
    .flag  (flag)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_flag_r <= flag;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.flag  = out_flag_r;

  // Both stages come out of reset empty.
  assert property (@(posedge clk) !rst_n |=> !in_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // A processed request always shows up in the result register.
  assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_valid_r)
    else $error("processed request produced no result");

  // A request held in the input stage is not dropped while it waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_item_r))
    else $error("waiting request lost");

  // A position load always reports zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item_r.kind == KIND_LOAD |=> !out_flag_r)
    else $error("load request gave a nonzero flag");

endmodule

// File: tb/sv/secc_tb_pkg.sv
`timescale 1ns / 1ps

package secc_tb_pkg;
  import secc_pkg::*;

  // Scoreboard for the stall checker. It keeps its own copy of the
  // registers and of the tracking state, works out the flag of every
  // accepted request and matches the results against them in order.
  class stall_scoreboard;
    // Register copies.
    bit                enc_on;
    bit [WINDOW_W-1:0] step_win;
    bit [WINDOW_W-1:0] enc_win;
    bit [RATIO_W-1:0]  enc_ratio;

    // Tracking state, two's complement with FRAC_BITS fraction bits.
    bit [POS_W-1:0] position;
    bit [POS_W-1:0] upper;
    bit [POS_W-1:0] lower;
    bit [POS_W-1:0] ideal;

    // Flags still owed by the block, oldest first.
    bit flag_q[$];

    int errors;
    int requests;
    int crossings;
    int checks_ok;
    int checks_bad;
    int loads;

    // A register write; each register keeps only its own width.
    function void apply_reg(input logic [CFG_IDX_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_ENC_PRESENT:  enc_on = data[0];
        REG_STEP_WINDOW:  step_win = data[WINDOW_W-1:0];
        REG_ENC_WINDOW:   enc_win = data[WINDOW_W-1:0];
        REG_ENC_PER_STEP: enc_ratio = data[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    // Update the tracking state for one accepted request and queue its flag.
    function void note_request(input item_t req);
      bit [POS_W-1:0] meas;
      bit [POS_W-1:0] diff;
      bit [POS_W-1:0] base;
      bit             flag;
      flag = 1'b0;
      requests++;
      case (req.kind)
        KIND_STEP: begin
          if (enc_on) begin
            position = req.direction ? position + STEP_ONE : position - STEP_ONE;
            // The upper bound wins when both bounds are passed at once.
            if ($signed(position) > $signed(upper)) begin
              upper = upper + {2'b00, step_win};
              lower = lower + {2'b00, step_win};
              ideal = ideal + {2'b00, enc_win};
              flag = 1'b1;
            end else if ($signed(lower) > $signed(position)) begin
              upper = upper - {2'b00, step_win};
              lower = lower - {2'b00, step_win};
              ideal = ideal - {2'b00, enc_win};
              flag = 1'b1;
            end
            if (flag) crossings++;
          end
        end
        KIND_CHECK: begin
          if (!enc_on) begin
            flag = 1'b1;
          end else begin
            meas = {{(POS_W-COUNT_W){req.encoder_count[COUNT_W-1]}}, req.encoder_count};
            meas = meas << FRAC_BITS;
            diff = ideal - meas;
            // A difference of -2^63 stays at 2^63 and so always fails.
            if (diff[POS_W-1]) diff = -diff;
            flag = (diff <= {2'b00, enc_win});
            if (flag) checks_ok++;
            else checks_bad++;
          end
        end
        KIND_LOAD: begin
          base = {{(POS_W-COUNT_W){req.load_position[COUNT_W-1]}}, req.load_position};
          position = base << FRAC_BITS;
          upper = position + {2'b00, step_win};
          lower = position - {2'b00, step_win};
          ideal = base * {{(POS_W-RATIO_W){1'b0}}, enc_ratio};
          loads++;
        end
        default: ;
      endcase
      flag_q.push_back(flag);
    endfunction

    // Match one result against the oldest outstanding flag.
    function void check_result(input logic got);
      bit want;
      if (flag_q.size() == 0) begin
        $error("flag %0b arrived with no request outstanding", got);
        errors++;
        return;
      end
      want = flag_q.pop_front();
      if (got !== want) begin
        $error("flag mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return flag_q.size();
    endfunction

    // Whole encoder ticks of the ideal position, cut to the count width.
    function logic [COUNT_W-1:0] ideal_ticks();
      return ideal[FRAC_BITS+COUNT_W-1:FRAC_BITS];
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import secc_pkg::*;
  import secc_tb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 32'sh8000_0000;
  localparam logic [CFG_DATA_W-1:0] ALL_ONES = {CFG_DATA_W{1'b1}};
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 158;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned TIMEOUT_NS = 5_000_000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  secc_in_if in_ch ();
  secc_out_if out_ch ();

  stall_scoreboard sb = new;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit hold_request;
  bit run_dir;
  int settings_used;

  stepper_encoder_stall_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run length.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: ready is chosen at each falling edge; a requested hold-off
  // keeps it low for a long stretch so that the block backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.flag);
  end

  function automatic item_t request_of(input logic [KIND_W-1:0] kind, input logic dir,
                                       input logic signed [COUNT_W-1:0] count,
                                       input logic signed [COUNT_W-1:0] pos);
    item_t r;
    r.kind = kind;
    r.direction = dir;
    r.encoder_count = count;
    r.load_position = pos;
    return r;
  endfunction

  // Random request shaped to reach window crossings and near-miss checks:
  // steps mostly run in one direction, checks mostly land near the ideal count.
  function automatic item_t random_request();
    item_t r;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    r.direction = 1'($urandom_range(1));
    r.encoder_count = $urandom;
    r.load_position = $urandom;
    if (pick < 55) begin
      r.kind = KIND_STEP;
      if ($urandom_range(9) == 0) run_dir = ~run_dir;
      r.direction = ($urandom_range(9) < 8) ? run_dir : ~run_dir;
    end else if (pick < 85) begin
      r.kind = KIND_CHECK;
      if ($urandom_range(9) < 7) begin
        span = (sb.enc_win[WINDOW_W-1:FRAC_BITS] > 6) ? 6 : sb.enc_win[WINDOW_W-1:FRAC_BITS];
        r.encoder_count = sb.ideal_ticks() + $urandom_range(2 * span + 4) - (span + 2);
      end
    end else if (pick < 95) begin
      r.kind = KIND_LOAD;
      if ($urandom_range(3) != 0) r.load_position = $signed($urandom_range(2000)) - 1000;
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_window();
    logic [CFG_DATA_W-1:0] frac;
    frac = $urandom_range(1) ? CFG_DATA_W'($urandom >> 1) : '0;
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2, 3: return CFG_DATA_W'({$urandom, $urandom});
      default: return (CFG_DATA_W'($urandom_range(1, 6)) << FRAC_BITS) | frac;
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  // Called and returns at a falling edge.
  task automatic send_request(input item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= r.kind;
    in_ch.direction <= r.direction;
    in_ch.encoder_count <= r.encoder_count;
    in_ch.load_position <= r.load_position;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed result, then let the pipeline empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    sb.apply_reg(index, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] present_d, step_d, enc_d,
                              input logic [CFG_DATA_W-1:0] ratio_d);
    cfg_write(REG_ENC_PRESENT, present_d);
    cfg_write(REG_STEP_WINDOW, step_d);
    cfg_write(REG_ENC_WINDOW, enc_d);
    cfg_write(REG_ENC_PER_STEP, ratio_d);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] present_d;
    logic [CFG_DATA_W-1:0] step_d;
    logic [CFG_DATA_W-1:0] enc_d;
    logic [CFG_DATA_W-1:0] ratio_d;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_STEP;
    in_ch.direction <= 1'b0;
    in_ch.encoder_count <= '0;
    in_ch.load_position <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ENC_PRESENT;
    cfg_data <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b0;
    run_dir = 1'b1;
    settings_used = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers at reset values: no encoder, so steps and loads give 0 and
    // checks pass.
    send_request(request_of(KIND_STEP, 1'b1, '0, '0));
    send_request(request_of(KIND_STEP, 1'b0, '0, '0));
    send_request(request_of(KIND_CHECK, 1'b0, COUNT_MAX, '0));
    send_request(request_of(KIND_UNUSED, 1'b1, COUNT_MIN, COUNT_MAX));
    send_request(request_of(KIND_LOAD, 1'b0, '0, 32'sd5));
    settle();

    // Small windows with over-wide register data: cross upward, check on
    // both sides of the allowed error, cross downward, then extreme counts.
    program_regs(ALL_ONES, CFG_DATA_W'(2) << FRAC_BITS, CFG_DATA_W'(1) << FRAC_BITS, ALL_ONES);
    send_request(request_of(KIND_LOAD, 1'b0, '0, '0));
    repeat (3) send_request(request_of(KIND_STEP, 1'b1, '0, '0));
    send_request(request_of(KIND_CHECK, 1'b0, 32'sd1, '0));
    send_request(request_of(KIND_CHECK, 1'b0, 32'sd3, '0));
    repeat (4) send_request(request_of(KIND_STEP, 1'b0, '0, '0));
    send_request(request_of(KIND_CHECK, 1'b0, COUNT_MIN, '0));
    send_request(request_of(KIND_CHECK, 1'b0, COUNT_MAX, '0));
    send_request(request_of(KIND_UNUSED, 1'b0, '0, '0));
    settle();

    // Widen the window without a new load so the lower bound wraps past the
    // upper one; the next step then passes both bounds at once.
    program_regs(CFG_DATA_W'(1), CFG_DATA_W'(1) << FRAC_BITS, ALL_ONES,
                 CFG_DATA_W'(1) << 35);
    send_request(request_of(KIND_LOAD, 1'b0, '0, COUNT_MIN));
    settle();
    program_regs(CFG_DATA_W'(1), ALL_ONES, ALL_ONES, CFG_DATA_W'(1) << 35);
    repeat (3) send_request(request_of(KIND_STEP, 1'b0, '0, '0));

    // Ideal count of 2^62 against the lowest count: the error is exactly
    // 2^63 and must fail even with the widest allowed error.
    send_request(request_of(KIND_LOAD, 1'b0, '0, COUNT_MAX));
    send_request(request_of(KIND_LOAD, 1'b0, '0, 32'sd134217728));
    send_request(request_of(KIND_CHECK, 1'b0, COUNT_MIN, '0));
    send_request(request_of(KIND_CHECK, 1'b0, COUNT_MAX, '0));

    // Random phases, each with its own register setting and a fresh load.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      send_idle_pct = (ph < 4) ? 23 : (ph < 8) ? 57 : 0;
      recv_idle_pct = (ph < 4) ? 57 : (ph < 8) ? 23 : 0;
      present_d = CFG_DATA_W'({$urandom, $urandom});
      present_d[0] = !(ph == 3 || ph == 8);
      if (ph == 0) begin
        step_d = '0;
        enc_d = '0;
      end else if (ph == 1) begin
        step_d = ALL_ONES;
        enc_d = ALL_ONES;
      end else begin
        step_d = random_window();
        enc_d = random_window();
      end
      case ($urandom_range(5))
        0: ratio_d = '0;
        1: ratio_d = CFG_DATA_W'({RATIO_W{1'b1}});
        2: ratio_d = CFG_DATA_W'({$urandom, $urandom});
        default: ratio_d = (CFG_DATA_W'($urandom_range(1, 3)) << FRAC_BITS) |
                           CFG_DATA_W'($urandom >> 1);
      endcase
      program_regs(present_d, step_d, enc_d, ratio_d);
      send_request(request_of(KIND_LOAD, 1'($urandom_range(1)), $urandom,
                              $signed($urandom_range(2000)) - 1000));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 40 && (ph == 2 || ph == 9)) hold_request = 1'b1;
        // Sender pause: nothing new until every owed result is back.
        if (n == 90 && (ph == 5 || ph == 10)) begin
          in_ch.valid <= 1'b0;
          do @(negedge clk); while (sb.pending() != 0);
        end
        send_request(random_request());
      end
    end

    settle();
    repeat (10) @(negedge clk);
    $display("Ran %0d requests over %0d register settings, with idling and stalls on both sides.",
             sb.requests, settings_used);
    $display("Saw %0d window crossings, %0d passing and %0d failing checks, %0d position loads.",
             sb.crossings, sb.checks_ok, sb.checks_bad, sb.loads);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
